// ===== hdl/bep_pkg.sv =====
// Shared types, constants and register codes of the boundary edge point scanner.
`timescale 1ns / 1ps
`default_nettype none

package bep_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int POS_W          = 10;
	localparam int TOL_W          = 8;
	localparam int APB_DW         = 32;
	localparam int APB_AW         = 4;

	localparam logic [TOL_W-1:0] TOL_RST = 8'd3;
	localparam logic [POS_W-1:0] IMG_W_RST = 10'd400;
	localparam logic [POS_W-1:0] IMG_H_RST = 10'd400;

	typedef enum logic [1:0] {
		REG_TOL    = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} bep_reg_t;

	typedef enum logic [1:0] {
		SIDE_LEFT   = 2'd0,
		SIDE_TOP    = 2'd1,
		SIDE_RIGHT  = 2'd2,
		SIDE_BOTTOM = 2'd3
	} bep_side_t;

	typedef struct packed {
		logic [TOL_W-1:0] tol;
		logic [POS_W-1:0] width;
		logic [POS_W-1:0] height;
	} bep_cfg_t;

	typedef struct packed {
		logic             is_col;
		logic             start;
		logic             pix_set;
		logic [POS_W-1:0] line;
		logic [POS_W-1:0] pos;
		logic             line_end;
	} bep_item_t;

	typedef struct packed {
		bep_side_t        side;
		logic             restart;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} bep_result_t;

endpackage

`default_nettype wire

// ===== hdl/bep_cfg.sv =====
// APB configuration registers: tolerance, image width and image height.
`timescale 1ns / 1ps
`default_nettype none

module bep_cfg
	import bep_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output bep_cfg_t               cfg
);

	logic [TOL_W-1:0] tol_q;
	logic [POS_W-1:0] width_q;
	logic [POS_W-1:0] height_q;
	logic             wr_en;
	bep_reg_t         reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = bep_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= TOL_RST;
			width_q  <= IMG_W_RST;
			height_q <= IMG_H_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TOL:    tol_q    <= pwdata[TOL_W-1:0];
				REG_WIDTH:  width_q  <= pwdata[POS_W-1:0];
				REG_HEIGHT: height_q <= pwdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TOL:    prdata = APB_DW'(tol_q);
			REG_WIDTH:  prdata = APB_DW'(width_q);
			REG_HEIGHT: prdata = APB_DW'(height_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.tol    = tol_q;
	assign cfg.width  = width_q;
	assign cfg.height = height_q;

endmodule

`default_nettype wire

// ===== hdl/bep_track.sv =====
// Line tracking and extreme tests; updates state when the staged word advances.
`timescale 1ns / 1ps
`default_nettype none

module bep_track
	import bep_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire bep_cfg_t    cfg,
	input  wire logic        valid_s1,
	input  wire bep_item_t   item_s1,
	input  wire logic [1:0]  room,
	output logic             adv,
	output logic [1:0]       nres,
	output bep_result_t      res0,
	output bep_result_t      res1
);

	localparam int CW = COORD_BITS;
	localparam int SW = ((CW > TOL_W) ? CW : TOL_W) + 1;

	logic [CW-1:0] left_q, right_q, top_q, bottom_q;
	logic [CW-1:0] first_q, last_q;
	logic          has_q;

	logic [CW-1:0] pos_c, line_c;
	logic [CW-1:0] near_b, far_b, first_b, last_b;
	logic [CW-1:0] first_n, last_n, near_new, far_new;
	logic          has_b, has_n, decide;
	logic          near_ok, far_ok, near_rs, far_rs;
	logic [SW-1:0] tol_w;
	bep_result_t   near_res, far_res;

	always_comb begin
		pos_c   = CW'(item_s1.pos);
		line_c  = CW'(item_s1.line);
		tol_w   = SW'(cfg.tol);
		if (item_s1.start) begin
			near_b  = item_s1.is_col ? CW'(cfg.height) : CW'(cfg.width);
			far_b   = '0;
			has_b   = 1'b0;
			first_b = '0;
			last_b  = '0;
		end else begin
			near_b  = item_s1.is_col ? top_q : left_q;
			far_b   = item_s1.is_col ? bottom_q : right_q;
			has_b   = has_q;
			first_b = first_q;
			last_b  = last_q;
		end
		first_n = (item_s1.pix_set && !has_b) ? pos_c : first_b;
		last_n  = item_s1.pix_set ? pos_c : last_b;
		has_n   = has_b || item_s1.pix_set;
		decide  = item_s1.line_end && has_n;

		near_ok = decide && (SW'(first_n) <= SW'(near_b) + tol_w);
		near_rs = (SW'(first_n) + tol_w) < SW'(near_b);
		far_ok  = decide && ((SW'(last_n) + tol_w) >= SW'(far_b));
		far_rs  = SW'(last_n) > (SW'(far_b) + tol_w);

		near_new = near_ok ? first_n : near_b;
		far_new  = far_ok ? last_n : far_b;

		nres = {1'b0, near_ok} + {1'b0, far_ok};
		adv  = valid_s1 && (nres <= room);

		near_res.side    = item_s1.is_col ? SIDE_TOP : SIDE_LEFT;
		near_res.restart = near_rs;
		near_res.row     = item_s1.is_col ? POS_W'(first_n) : POS_W'(line_c);
		near_res.col     = item_s1.is_col ? POS_W'(line_c) : POS_W'(first_n);
		near_res.last    = !far_ok;

		far_res.side     = item_s1.is_col ? SIDE_BOTTOM : SIDE_RIGHT;
		far_res.restart  = far_rs;
		far_res.row      = item_s1.is_col ? POS_W'(last_n) : POS_W'(line_c);
		far_res.col      = item_s1.is_col ? POS_W'(line_c) : POS_W'(last_n);
		far_res.last     = 1'b1;

		res0 = near_ok ? near_res : far_res;
		res1 = far_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= CW'(IMG_W_RST);
			right_q  <= '0;
			top_q    <= CW'(IMG_H_RST);
			bottom_q <= '0;
			first_q  <= '0;
			last_q   <= '0;
			has_q    <= 1'b0;
		end else if (adv) begin
			if (item_s1.is_col) begin
				top_q    <= near_new;
				bottom_q <= far_new;
			end else begin
				left_q   <= near_new;
				right_q  <= far_new;
			end
			if (item_s1.line_end) begin
				first_q <= '0;
				last_q  <= '0;
				has_q   <= 1'b0;
			end else begin
				first_q <= first_n;
				last_q  <= last_n;
				has_q   <= has_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bep_out_q.sv =====
// Two-entry result buffer; takes up to two result words per cycle as room allows, sends one unless out_stall holds it.
`timescale 1ns / 1ps
`default_nettype none

module bep_out_q
	import bep_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [1:0]  push,
	input  wire bep_result_t res0,
	input  wire bep_result_t res1,
	input  wire logic        out_stall,
	output logic             out_valid,
	output logic [1:0]       room,
	output bep_result_t      head
);

	logic [1:0]  cnt_q, cnt_d, kept;
	logic        pop;
	bep_result_t slot_q [2];
	bep_result_t slot_d [2];

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign kept      = cnt_q - {1'b0, pop};
	assign room      = 2'd2 - kept;
	assign cnt_d     = kept + push;
	assign head      = slot_q[0];

	always_comb begin
		slot_d[0] = pop ? slot_q[1] : slot_q[0];
		slot_d[1] = slot_q[1];
		case (kept)
			2'd0: begin
				slot_d[0] = res0;
				slot_d[1] = res1;
			end
			2'd1: begin
				slot_d[1] = res0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_q[0] <= slot_d[0];
		slot_q[1] <= slot_d[1];
	end

`ifndef NO_ASSERTIONS
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("result buffer count overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n) push <= room)
		else $error("results pushed beyond free room");
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !slot_q[0].last) |-> slot_q[1].last)
		else $error("non-final word not followed by final word");
`endif

endmodule

`default_nettype wire

// ===== hdl/boundary_edge_point_scanner_top.sv =====
// Boundary edge point scanner: pixel words in, boundary point words out.
// Path: an accepted pixel word is held in the input stage, then its results enter the result buffer.
// Throughput: one pixel word per cycle; a line end can give two results, sent one at a time
// from the two-entry result buffer, so the input stalls when a word's results exceed its free room.
// Reset: arst_n clears the input stage, result buffer and tracking state; registers
// return to tolerance 3, width 400, height 400. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module boundary_edge_point_scanner_top
	import bep_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              kind,
	input  wire logic              pass_start,
	input  wire logic              pixel_set,
	input  wire logic [POS_W-1:0]  line_index,
	input  wire logic [POS_W-1:0]  position,
	input  wire logic              line_end,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             side,
	output logic                   restart,
	output logic [POS_W-1:0]       row,
	output logic [POS_W-1:0]       col,
	output logic                   last,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	bep_cfg_t    cfg;
	bep_item_t   item_s1;
	logic        valid_s1;
	logic        adv, load;
	logic [1:0]  nres, room;
	bep_result_t res0, res1, head;

	assign in_stall = valid_s1 && !adv;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.is_col   <= kind;
			item_s1.start    <= pass_start;
			item_s1.pix_set  <= pixel_set;
			item_s1.line     <= line_index;
			item_s1.pos      <= position;
			item_s1.line_end <= line_end;
		end
	end

	bep_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bep_track #(
		.COORD_BITS (COORD_BITS)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.room     (room),
		.adv      (adv),
		.nres     (nres),
		.res0     (res0),
		.res1     (res1)
	);

	bep_out_q u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv ? nres : 2'd0),
		.res0      (res0),
		.res1      (res1),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.room      (room),
		.head      (head)
	);

	assign side    = head.side;
	assign restart = head.restart;
	assign row     = head.row;
	assign col     = head.col;
	assign last    = head.last;

endmodule

`default_nettype wire
